// ----- sv/bcle_pkg.sv -----
// ----------------------------------------------------------------------------
// bcle_pkg
// Shared types and constants of the button click / long-press event block.
// ----------------------------------------------------------------------------
package bcle_pkg;

  // Widths of the channel fields
  localparam int unsigned PinW   = 8;   // buttons visible on the pin and mask fields
  localparam int unsigned TimeW  = 32;  // millisecond timestamp
  localparam int unsigned MsW    = 16;  // threshold registers
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    RegPressEn   = 3'd0,
    RegReleaseEn = 3'd1,
    RegClickEn   = 3'd2,
    RegLongEn    = 3'd3,
    RegLongMs    = 3'd4,
    RegClickMs   = 3'd5
  } bcle_reg_e;

  // Per-button enables seen by one lane
  typedef struct packed {
    logic press;
    logic lng;
    logic click;
    logic rel;
  } bcle_lane_en_t;

  // Events found by one lane on one tick
  typedef struct packed {
    logic press;
    logic lng;
    logic click;
    logic rel;
  } bcle_lane_ev_t;

  // Merged event masks of one result beat
  typedef struct packed {
    logic [PinW-1:0] press;
    logic [PinW-1:0] lng;
    logic [PinW-1:0] click;
    logic [PinW-1:0] rel;
  } bcle_ev_t;

endpackage

// ----- sv/bcle_lane.sv -----
// ----------------------------------------------------------------------------
// bcle_lane
// One button: edge detection, hold timing and long-press bookkeeping.
// ----------------------------------------------------------------------------
module bcle_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic [bcle_pkg::TimeW-1:0]           now_i,
  input  logic                                 down_i,
  input  bcle_pkg::bcle_lane_en_t              en_i,
  input  logic [bcle_pkg::MsW-1:0]             long_press_ms_i,
  input  logic [bcle_pkg::MsW-1:0]             click_max_ms_i,
  output bcle_pkg::bcle_lane_ev_t              ev_o
);
  import bcle_pkg::*;

  logic             was_down_q, was_down_d;
  logic             long_done_q, long_done_d;
  logic [TimeW-1:0] hold_start_q, hold_start_d;
  logic [TimeW-1:0] elapsed;
  logic             rise, fall, held;

  // Classify the tick and time the hold (wraps modulo 2^32)
  assign elapsed = now_i - hold_start_q;
  assign rise    = down_i && !was_down_q;
  assign held    = down_i && was_down_q;
  assign fall    = !down_i && was_down_q;

  // Find events and next state
  always_comb begin
    ev_o         = '0;
    was_down_d   = down_i;
    long_done_d  = long_done_q;
    hold_start_d = hold_start_q;
    if (rise) begin
      hold_start_d = now_i;
      long_done_d  = 1'b0;
      ev_o.press   = en_i.press;
    end else if (held && !long_done_q) begin
      if (en_i.lng && (elapsed >= TimeW'(long_press_ms_i))) begin
        ev_o.lng    = 1'b1;
        long_done_d = 1'b1;
      end
    end else if (fall) begin
      ev_o.click = en_i.click && (elapsed <= TimeW'(click_max_ms_i));
      ev_o.rel   = en_i.rel;
    end
  end

  // Hold level and long-press flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_down_q  <= 1'b0;
      long_done_q <= 1'b0;
    end else if (accept_i) begin
      was_down_q  <= was_down_d;
      long_done_q <= long_done_d;
    end
  end

  // Hold start time, written on every press edge before any read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hold_start_q <= hold_start_d;
    end
  end

  // Long-press only fires inside a hold that has not fired yet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && ev_o.lng) |-> (held && !long_done_q))
    else $error("long-press outside an unfired hold");

  // Click only on a release edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && ev_o.click) |-> fall)
    else $error("click without a release edge");

  // Accepted level becomes the previous level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> (was_down_q == $past(down_i)))
    else $error("previous level not tracked");

  // A firing sets the flag for the rest of the hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && ev_o.lng) |=> long_done_q)
    else $error("long-press flag not set");

endmodule

// ----- sv/bcle_merge.sv -----
// ----------------------------------------------------------------------------
// bcle_merge
// Gather lane events into masks and hold them in an output register with skid.
// ----------------------------------------------------------------------------
module bcle_merge #(
  parameter int unsigned NumButtons = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push_i,
  input  bcle_pkg::bcle_lane_ev_t [NumButtons-1:0] lane_ev_i,
  output logic                                    full_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output bcle_pkg::bcle_ev_t                      out_ev_o
);
  import bcle_pkg::*;

  bcle_ev_t merged;
  bcle_ev_t out_q, skid_q;
  logic     out_valid_q, skid_valid_q;
  logic     take;

  // Combine lanes into masks; lanes past the mask width are dropped
  for (genvar i = 0; i < PinW; i++) begin : g_bit
    if (i < NumButtons) begin : g_on
      assign merged.press[i] = lane_ev_i[i].press;
      assign merged.lng[i]   = lane_ev_i[i].lng;
      assign merged.click[i] = lane_ev_i[i].click;
      assign merged.rel[i]   = lane_ev_i[i].rel;
    end else begin : g_off
      assign merged.press[i] = 1'b0;
      assign merged.lng[i]   = 1'b0;
      assign merged.click[i] = 1'b0;
      assign merged.rel[i]   = 1'b0;
    end
  end

  assign take = out_valid_q && !out_stall_i;

  // Advance output and skid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Move payload with the valid bits
  always_ff @(posedge clk_i) begin
    if (take && skid_valid_q) begin
      out_q <= skid_q;
    end else if (push_i && (take || !out_valid_q)) begin
      out_q <= merged;
    end
    if (push_i && out_valid_q && !take) begin
      skid_q <= merged;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_ev_o    = out_q;

  // Skid only holds a beat behind a waiting output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat with output empty");

  // No beat is pushed while the skid is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("push into full buffer");

  // After a push the output always holds a valid beat on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> out_valid_q)
    else $error("pushed beat lost");

endmodule

// ----- sv/button_click_longpress_events.sv -----
// ----------------------------------------------------------------------------
// button_click_longpress_events
// Per-button press, long-press, click and release event detector.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  in       | in_valid_i / in_stall_o    | now_ms_i, pressed_pins_i
//  out      | out_valid_o / out_stall_i  | press/long/click/release_events_o
//  cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
//  One tick is accepted per cycle while in_stall_o is low. Each button has its
//  own lane; the lane logic is one 32-bit subtract and two compares, and the
//  merge stage registers the masks in its output register or its skid.
//  Reset clears enables, sets long_press_ms to 1000 and click_max_ms to 500,
//  and marks every button released.
//  in_stall_o rises only when both the output register and the skid hold beats.
// ----------------------------------------------------------------------------
module button_click_longpress_events #(
  parameter int unsigned NumButtons = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bcle_pkg::TimeW-1:0]      now_ms_i,
  input  logic [bcle_pkg::PinW-1:0]       pressed_pins_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bcle_pkg::PinW-1:0]       press_events_o,
  output logic [bcle_pkg::PinW-1:0]       long_events_o,
  output logic [bcle_pkg::PinW-1:0]       click_events_o,
  output logic [bcle_pkg::PinW-1:0]       release_events_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bcle_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bcle_pkg::CfgDatW-1:0]    cfg_data_i
);
  import bcle_pkg::*;

  logic [PinW-1:0] press_en_q, release_en_q, click_en_q, long_en_q;
  logic [MsW-1:0]  long_ms_q, click_ms_q;
  logic            accept;
  logic            full;
  bcle_ev_t        out_ev;
  bcle_lane_ev_t [NumButtons-1:0] lane_ev;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !full;
  assign in_stall_o  = full;

  // Configuration registers; unused indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_en_q   <= '0;
      release_en_q <= '0;
      click_en_q   <= '0;
      long_en_q    <= '0;
      long_ms_q    <= MsW'(1000);
      click_ms_q   <= MsW'(500);
    end else if (cfg_valid_i) begin
      case (bcle_reg_e'(cfg_index_i))
        RegPressEn:   press_en_q   <= cfg_data_i[PinW-1:0];
        RegReleaseEn: release_en_q <= cfg_data_i[PinW-1:0];
        RegClickEn:   click_en_q   <= cfg_data_i[PinW-1:0];
        RegLongEn:    long_en_q    <= cfg_data_i[PinW-1:0];
        RegLongMs:    long_ms_q    <= cfg_data_i[MsW-1:0];
        RegClickMs:   click_ms_q   <= cfg_data_i[MsW-1:0];
        default:      ;
      endcase
    end
  end

  // One lane per button; buttons past the pin field never see a press
  for (genvar i = 0; i < NumButtons; i++) begin : g_lane
    logic          down;
    bcle_lane_en_t en;
    if (i < PinW) begin : g_pin
      assign down     = pressed_pins_i[i];
      assign en.press = press_en_q[i];
      assign en.lng   = long_en_q[i];
      assign en.click = click_en_q[i];
      assign en.rel   = release_en_q[i];
    end else begin : g_nopin
      assign down = 1'b0;
      assign en   = '0;
    end

    bcle_lane u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .accept_i        (accept),
      .now_i           (now_ms_i),
      .down_i          (down),
      .en_i            (en),
      .long_press_ms_i (long_ms_q),
      .click_max_ms_i  (click_ms_q),
      .ev_o            (lane_ev[i])
    );
  end

  // Merge lanes and buffer the result beat
  bcle_merge #(
    .NumButtons (NumButtons)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .lane_ev_i   (lane_ev),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_ev_o    (out_ev)
  );

  assign press_events_o   = out_ev.press;
  assign long_events_o    = out_ev.lng;
  assign click_events_o   = out_ev.click;
  assign release_events_o = out_ev.rel;

endmodule

// ----- verif/button_click_longpress_events_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_click_longpress_events_tb
// Drives poll ticks into the button event detector and checks every result
// beat against a cycle-free predictor of the press, long-press, click and
// release rules. Directed ticks cover threshold boundaries, zero and full-scale
// thresholds, timestamp wrap, time running backwards and late enables; random
// phases follow with fresh register settings. Sender bursts and receiver
// stalls are randomized throughout.
// ----------------------------------------------------------------------------
module button_click_longpress_events_tb;
  import bcle_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // Indexes that no register decodes
  localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

  typedef enum int unsigned {
    StallNone,
    StallSparse,
    StallHeavy,
    StallToggle
  } stall_mode_e;

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [TimeW-1:0]    now_ms_i = '0;
  logic [PinW-1:0]     pressed_pins_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PinW-1:0]     press_events_o;
  logic [PinW-1:0]     long_events_o;
  logic [PinW-1:0]     click_events_o;
  logic [PinW-1:0]     release_events_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDatW-1:0]  cfg_data_i = '0;

  button_click_longpress_events dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .now_ms_i         (now_ms_i),
    .pressed_pins_i   (pressed_pins_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .press_events_o   (press_events_o),
    .long_events_o    (long_events_o),
    .click_events_o   (click_events_o),
    .release_events_o (release_events_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Predictor copy of the registers
  logic [PinW-1:0]  press_en;
  logic [PinW-1:0]  rel_en;
  logic [PinW-1:0]  click_en;
  logic [PinW-1:0]  long_en;
  logic [MsW-1:0]   long_ms;
  logic [MsW-1:0]   click_ms;

  // Predictor copy of the per-button state
  logic [PinW-1:0]  btn_down;
  logic [TimeW-1:0] hold_start_ms [PinW];
  logic [PinW-1:0]  long_fired;

  bcle_ev_t         expected_events_q [$];
  bcle_ev_t         want_ev;
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;

  // Sender burst bookkeeping and random tick source
  int unsigned      burst_left = 0;
  logic [TimeW-1:0] tick_now = '0;
  logic [PinW-1:0]  tick_pins = '0;

  stall_mode_e      stall_mode = StallNone;
  int unsigned      stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stall pattern: pick a random mode for each run of random length
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= StallNone;
      stall_left  <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        stall_left <= $urandom_range(4, 40);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        StallNone:   out_stall_i <= 1'b0;
        StallSparse: out_stall_i <= ($urandom_range(0, 2) == 0);
        StallHeavy:  out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // Work out the event masks of one tick and advance the button state
  function automatic bcle_ev_t predict_tick(input logic [TimeW-1:0] now,
                                            input logic [PinW-1:0] pins);
    bcle_ev_t         ev;
    logic [TimeW-1:0] held_ms;
    ev = '0;
    for (int b = 0; b < PinW; b++) begin
      held_ms = now - hold_start_ms[b];
      if (pins[b] && !btn_down[b]) begin
        hold_start_ms[b] = now;
        long_fired[b]    = 1'b0;
        ev.press[b]      = press_en[b];
      end else if (pins[b] && !long_fired[b]) begin
        if (long_en[b] && held_ms >= {16'h0, long_ms}) begin
          ev.lng[b]     = 1'b1;
          long_fired[b] = 1'b1;
        end
      end else if (!pins[b] && btn_down[b]) begin
        ev.click[b] = click_en[b] && (held_ms <= {16'h0, click_ms});
        ev.rel[b]   = rel_en[b];
      end
      btn_down[b] = pins[b];
    end
    return ev;
  endfunction

  task automatic check_field(input string field, input logic [PinW-1:0] want,
                             input logic [PinW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %02h actual %02h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each accepted result beat with the oldest pending expectation
  always @(posedge clk) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_events_q.size() == 0) begin
        $display("%0t: result beat with no tick pending, expected none actual %02h %02h %02h %02h",
                 $time, press_events_o, long_events_o, click_events_o, release_events_o);
        mismatch_count++;
      end else begin
        want_ev = expected_events_q.pop_front();
        check_field("press_events", want_ev.press, press_events_o);
        check_field("long_events", want_ev.lng, long_events_o);
        check_field("click_events", want_ev.click, click_events_o);
        check_field("release_events", want_ev.rel, release_events_o);
      end
    end
  end

  // Send one tick; valid stays high so the next beat can follow directly
  task automatic send_tick(input logic [TimeW-1:0] now, input logic [PinW-1:0] pins);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    now_ms_i       <= now;
    pressed_pins_i <= pins;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    expected_events_q.insert(expected_events_q.size(), predict_tick(now, pins));
  endtask

  // Write one register; the caller drops cfg_valid_i after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (cfg_ready_o !== 1'b1);
    case (idx)
      RegPressEn:   press_en = data[PinW-1:0];
      RegReleaseEn: rel_en   = data[PinW-1:0];
      RegClickEn:   click_en = data[PinW-1:0];
      RegLongEn:    long_en  = data[PinW-1:0];
      RegLongMs:    long_ms  = data;
      RegClickMs:   click_ms = data;
      default: ;
    endcase
  endtask

  // Drop valid and drain all pending results, then let the clock run idle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_events_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_all_regs(input logic [PinW-1:0] pe, input logic [PinW-1:0] re,
                              input logic [PinW-1:0] ce, input logic [PinW-1:0] le,
                              input logic [MsW-1:0] lms, input logic [MsW-1:0] cms);
    wait_idle();
    write_reg(RegPressEn,   {8'($urandom), pe});
    write_reg(RegReleaseEn, {8'($urandom), re});
    write_reg(RegClickEn,   {8'($urandom), ce});
    write_reg(RegLongEn,    {8'($urandom), le});
    write_reg(RegLongMs,    lms);
    write_reg(RegClickMs,   cms);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset values: enables off, so edges report nothing
  task automatic test_reset_values();
    send_tick(32'd0, 8'h00);
    send_tick(32'd10, 8'hFF);
    send_tick(32'd5000, 8'hFF);
    send_tick(32'd5001, 8'h00);
  endtask

  // Default thresholds of 1000 and 500 at their boundaries
  task automatic test_default_thresholds();
    wait_idle();
    write_reg(RegPressEn, 16'h00FF);
    write_reg(RegReleaseEn, 16'h00FF);
    write_reg(RegClickEn, 16'h00FF);
    write_reg(RegLongEn, 16'h00FF);
    cfg_valid_i <= 1'b0;
    send_tick(32'd100, 8'hFF);
    send_tick(32'd1099, 8'hFF);
    send_tick(32'd1100, 8'hFF);
    send_tick(32'd1200, 8'hFF);
    send_tick(32'd1300, 8'hF0);
    send_tick(32'd1800, 8'h00);
    send_tick(32'd2000, 8'h0F);
    send_tick(32'd2501, 8'h00);
  endtask

  // Timestamp wrap and time running backwards
  task automatic test_time_wrap();
    send_tick(32'hFFFF_FF00, 8'h01);
    send_tick(32'h0000_00F4, 8'h00);
    send_tick(32'd5000, 8'h02);
    send_tick(32'd4000, 8'h02);
    send_tick(32'd4001, 8'h00);
  endtask

  // Zero thresholds: no long-press on the edge tick, click only at zero hold
  task automatic test_zero_thresholds();
    set_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 16'd0);
    send_tick(32'd7000, 8'h81);
    send_tick(32'd7000, 8'h81);
    send_tick(32'd7000, 8'h00);
    send_tick(32'd8000, 8'h02);
    send_tick(32'd8001, 8'h00);
  endtask

  // Long-press disabled through a hold, then enabled before release
  task automatic test_late_enable();
    set_all_regs(8'h55, 8'hAA, 8'h0F, 8'h00, 16'd1000, 16'd500);
    send_tick(32'd10000, 8'h3C);
    send_tick(32'd12000, 8'h3C);
    wait_idle();
    write_reg(RegLongEn, 16'hFF0C);
    cfg_valid_i <= 1'b0;
    send_tick(32'd12001, 8'h3C);
    wait_idle();
    write_reg(RegLongEn, 16'h00FF);
    cfg_valid_i <= 1'b0;
    send_tick(32'd12002, 8'h3C);
    send_tick(32'd12003, 8'h00);
  endtask

  // Full-scale thresholds and writes to undecoded indexes
  task automatic test_full_scale();
    set_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    wait_idle();
    write_reg(RegSpareA, 16'hFFFF);
    write_reg(RegSpareB, 16'h0000);
    cfg_valid_i <= 1'b0;
    send_tick(32'd0, 8'h11);
    send_tick(32'd65534, 8'h11);
    send_tick(32'd65535, 8'h11);
    send_tick(32'd65535, 8'h10);
    send_tick(32'd70000, 8'h11);
    send_tick(32'd135536, 8'h00);
  endtask

  function automatic logic [MsW-1:0] pick_ms();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return MsW'($urandom_range(1, 800));
    endcase
  endfunction

  // Random phase: mostly toggles of a few buttons with small random time steps
  task automatic run_random_phase(input int unsigned n_ticks);
    int unsigned     step_max;
    int unsigned     r;
    logic [PinW-1:0] flip;
    step_max = ((long_ms > click_ms) ? long_ms : click_ms) / 3 + 20;
    repeat (n_ticks) begin
      r = $urandom_range(0, 99);
      if (r < 80) tick_now = tick_now + $urandom_range(0, step_max);
      else if (r < 88) tick_now = tick_now + $urandom;
      else if (r < 94) tick_now = tick_now - $urandom_range(1, step_max);
      else tick_now = $urandom;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        for (int b = 0; b < PinW; b++) flip[b] = ($urandom_range(0, 5) == 0);
        tick_pins = tick_pins ^ flip;
      end else if (r >= 85) begin
        tick_pins = PinW'($urandom);
      end
      send_tick(tick_now, tick_pins);
    end
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 16'd0);
        1: set_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        default: set_all_regs(($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom),
                              ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom),
                              ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom),
                              ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom),
                              pick_ms(), pick_ms());
      endcase
      if (ph == 3) tick_now = 32'hFFFF_F000;
      if (ph == 5) tick_now = $urandom;
      run_random_phase(160);
    end
  endtask

  initial begin
    press_en   = '0;
    rel_en     = '0;
    click_en   = '0;
    long_en    = '0;
    long_ms    = 16'd1000;
    click_ms   = 16'd500;
    btn_down   = '0;
    long_fired = '0;
    for (int b = 0; b < PinW; b++) hold_start_ms[b] = '0;

    // Hold reset, then release it once
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_default_thresholds();
    test_time_wrap();
    test_zero_thresholds();
    test_late_enable();
    test_full_scale();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
